// ===== sv/apc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_pkg
// Shared types and constants for the ARGB pixel compositor: field widths,
// compose mode codes, register indexes and the items passed between stages.
// ----------------------------------------------------------------------------
package apc_pkg;

    localparam int PIX_W      = 32;
    localparam int DEPTH_W    = 16;
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 3;
    localparam int PROD_W     = 2 * CHAN_W;
    localparam int MODE_W     = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // Compose mode codes. The fourth code is unused and writes nothing.
    localparam logic [MODE_W-1:0] MODE_COPY       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEPTH_COPY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BLEND      = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_COMPOSE_MODE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LAYER_DEPTH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GLOBAL_ALPHA = 2'd2;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // Register reset values.
    localparam logic [MODE_W-1:0]  RESET_MODE         = MODE_COPY;
    localparam logic [DEPTH_W-1:0] RESET_LAYER_DEPTH  = 16'h0000;
    localparam logic [CHAN_W-1:0]  RESET_GLOBAL_ALPHA = 8'hFF;

    typedef struct packed {
        logic [MODE_W-1:0]  compose_mode;
        logic [DEPTH_W-1:0] layer_depth;
        logic [CHAN_W-1:0]  global_alpha;
    } cfg_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] dst_depth;
        logic [PIX_W-1:0]   dst_pixel;
        logic [PIX_W-1:0]   src_pixel;
    } in_item_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] dst_depth;
        logic [PIX_W-1:0]   dst_pixel;
        logic [PIX_W-1:0]   src_pixel;
        logic [CHAN_W-1:0]  alpha;
        logic               depth_pass;
    } s1_item_t;

    typedef struct packed {
        logic [DEPTH_W-1:0]                  dst_depth;
        logic [PIX_W-1:0]                    dst_pixel;
        logic [PIX_W-1:0]                    src_pixel;
        logic [CHAN_W-1:0]                   alpha;
        logic                                depth_pass;
        logic [NUM_CHAN-1:0][PROD_W-1:0]     src_prod;
        logic [NUM_CHAN-1:0][PROD_W-1:0]     dst_prod;
    } s2_item_t;

    typedef struct packed {
        logic               depth_write;
        logic               pixel_write;
        logic [DEPTH_W-1:0] out_depth;
        logic [PIX_W-1:0]   out_pixel;
    } out_item_t;

endpackage

// ===== sv/apc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_cfg_regs
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module apc_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [apc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [apc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output apc_pkg::cfg_t                  cfg
);

    apc_pkg::cfg_t cfg_reg;
    apc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                apc_pkg::REG_COMPOSE_MODE:
                    cfg_next.compose_mode = cfg_wdata[apc_pkg::MODE_W-1:0];
                apc_pkg::REG_LAYER_DEPTH:
                    cfg_next.layer_depth = cfg_wdata[apc_pkg::DEPTH_W-1:0];
                apc_pkg::REG_GLOBAL_ALPHA:
                    cfg_next.global_alpha = cfg_wdata[apc_pkg::CHAN_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.compose_mode <= apc_pkg::RESET_MODE;
            cfg_reg.layer_depth  <= apc_pkg::RESET_LAYER_DEPTH;
            cfg_reg.global_alpha <= apc_pkg::RESET_GLOBAL_ALPHA;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/apc_alpha_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_alpha_stage
// First pipeline stage: scales source alpha by the global alpha and
// evaluates the depth test.
// ----------------------------------------------------------------------------
module apc_alpha_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  apc_pkg::cfg_t        cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  apc_pkg::in_item_t    in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output apc_pkg::s1_item_t    out_item
);

    logic                        valid_reg;
    logic                        valid_next;
    apc_pkg::s1_item_t           item_reg;
    apc_pkg::s1_item_t           item_next;
    logic [apc_pkg::CHAN_W-1:0]  src_alpha;
    logic [apc_pkg::PROD_W-1:0]  alpha_prod;

    assign in_ready   = !valid_reg || out_ready;
    assign src_alpha  = in_item.src_pixel[apc_pkg::PIX_W-1 -: apc_pkg::CHAN_W];
    assign alpha_prod = src_alpha * cfg.global_alpha;

    always_comb
    begin
        item_next.src_pixel  = in_item.src_pixel;
        item_next.dst_pixel  = in_item.dst_pixel;
        item_next.dst_depth  = in_item.dst_depth;
        item_next.depth_pass = (in_item.dst_depth <= cfg.layer_depth);
        // A global alpha of full opacity leaves the source alpha untouched.
        if (cfg.global_alpha == apc_pkg::ALPHA_OPAQUE)
            item_next.alpha = src_alpha;
        else
            item_next.alpha = alpha_prod[apc_pkg::PROD_W-1 -: apc_pkg::CHAN_W];
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== sv/apc_mul_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_mul_stage
// Second pipeline stage: forms the per-channel products s*a and d*(255-a).
// ----------------------------------------------------------------------------
module apc_mul_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  apc_pkg::s1_item_t    in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output apc_pkg::s2_item_t    out_item
);

    logic                        valid_reg;
    logic                        valid_next;
    apc_pkg::s2_item_t           item_reg;
    apc_pkg::s2_item_t           item_next;
    logic [apc_pkg::CHAN_W-1:0]  inv_alpha;

    assign in_ready  = !valid_reg || out_ready;
    assign inv_alpha = apc_pkg::ALPHA_OPAQUE - in_item.alpha;

    always_comb
    begin
        item_next.src_pixel  = in_item.src_pixel;
        item_next.dst_pixel  = in_item.dst_pixel;
        item_next.dst_depth  = in_item.dst_depth;
        item_next.alpha      = in_item.alpha;
        item_next.depth_pass = in_item.depth_pass;
        for (int c = 0; c < apc_pkg::NUM_CHAN; c++)
        begin
            item_next.src_prod[c] =
                in_item.src_pixel[c*apc_pkg::CHAN_W +: apc_pkg::CHAN_W] * in_item.alpha;
            item_next.dst_prod[c] =
                in_item.dst_pixel[c*apc_pkg::CHAN_W +: apc_pkg::CHAN_W] * inv_alpha;
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== sv/apc_mix_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_mix_stage
// Final pipeline stage: sums the channel products, selects the result by
// compose mode and holds it in the output register.
// ----------------------------------------------------------------------------
module apc_mix_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  apc_pkg::cfg_t        cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  apc_pkg::s2_item_t    in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output apc_pkg::out_item_t   out_item
);

    logic                        valid_reg;
    logic                        valid_next;
    apc_pkg::out_item_t          item_reg;
    apc_pkg::out_item_t          item_next;
    logic [apc_pkg::PIX_W-1:0]   blend_pixel;
    logic [apc_pkg::PIX_W-1:0]   scaled_src;
    logic [apc_pkg::PROD_W-1:0]  chan_sum [apc_pkg::NUM_CHAN];

    assign in_ready   = !valid_reg || out_ready;
    assign scaled_src = {in_item.alpha,
                         in_item.src_pixel[apc_pkg::PIX_W-apc_pkg::CHAN_W-1:0]};

    always_comb
    begin
        blend_pixel = {apc_pkg::ALPHA_OPAQUE, {(apc_pkg::PIX_W-apc_pkg::CHAN_W){1'b0}}};
        for (int c = 0; c < apc_pkg::NUM_CHAN; c++)
        begin
            // The sum is at most 255*255, so it fits the product width.
            chan_sum[c] = in_item.src_prod[c] + in_item.dst_prod[c];
            blend_pixel[c*apc_pkg::CHAN_W +: apc_pkg::CHAN_W] =
                chan_sum[c][apc_pkg::PROD_W-1 -: apc_pkg::CHAN_W];
        end
    end

    always_comb
    begin
        item_next.out_pixel   = in_item.dst_pixel;
        item_next.out_depth   = in_item.dst_depth;
        item_next.pixel_write = 1'b0;
        item_next.depth_write = 1'b0;
        unique case (cfg.compose_mode)
            apc_pkg::MODE_COPY:
            begin
                item_next.out_pixel   = in_item.src_pixel;
                item_next.pixel_write = 1'b1;
            end
            apc_pkg::MODE_DEPTH_COPY:
            begin
                if (in_item.depth_pass)
                begin
                    item_next.out_pixel   = in_item.src_pixel;
                    item_next.out_depth   = cfg.layer_depth;
                    item_next.pixel_write = 1'b1;
                    item_next.depth_write = 1'b1;
                end
            end
            apc_pkg::MODE_BLEND:
            begin
                // An opaque source passes through with its scaled alpha.
                if (in_item.alpha == apc_pkg::ALPHA_OPAQUE)
                    item_next.out_pixel = scaled_src;
                else
                    item_next.out_pixel = blend_pixel;
                item_next.pixel_write = 1'b1;
            end
            default:
            begin
                item_next.pixel_write = 1'b0;
            end
        endcase
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== sv/argb_pixel_compositor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// argb_pixel_compositor
// Per-pixel ARGB8888 compositor with plain copy, depth-tested copy and
// alpha blend with a global alpha.
// ----------------------------------------------------------------------------
// Usage:
// Each item on the slave stream carries a source pixel, the destination
// pixel and the destination depth. Each item gives exactly one result item
// on the master stream: the pixel and depth to store plus a write flag for
// each. The compose mode, layer depth and global alpha are set through the
// configuration write port and must only change while no item is in flight.
// The pipeline has three register stages: alpha scaling and depth compare,
// the channel multipliers, then the channel sums and mode select feeding the
// output register. The block takes one item per cycle while it is not stalled.
// Every stage holds its own valid bit, so a stall at m_tready backs up stage
// by stage: empty stages keep filling, and s_tready falls only when all
// three stages hold an item. No item is lost or repeated.
// Reset empties the pipeline and loads copy mode, layer depth zero and a
// global alpha of 255.
// ----------------------------------------------------------------------------
module argb_pixel_compositor
(
    input  logic                           clk,
    input  logic                           rst_n,

    // Configuration write port.
    input  logic                           cfg_we,
    input  logic [apc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [apc_pkg::CFG_DATA_W-1:0] cfg_wdata,

    // Input stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata from bit 0 up: src_pixel[31:0], dst_pixel[63:32], dst_depth[79:64].
    input  logic [79:0]                    s_tdata,

    // Output stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata from bit 0 up: out_pixel[31:0], out_depth[47:32], pixel_write[48],
    // depth_write[49], zero fill [55:50].
    output logic [55:0]                    m_tdata
);

    apc_pkg::cfg_t      cfg;
    apc_pkg::in_item_t  in_item;
    apc_pkg::s1_item_t  s1_item;
    apc_pkg::s2_item_t  s2_item;
    apc_pkg::out_item_t out_item;
    logic               s1_valid;
    logic               s1_ready;
    logic               s2_valid;
    logic               s2_ready;

    // Unpack the input item; fields sit back to back from bit zero.
    assign in_item = s_tdata;

    apc_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Stage one: global alpha scaling and the depth compare.
    apc_alpha_stage u_alpha_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_item  (s1_item)
    );

    // Stage two: six 8x8 channel products.
    apc_mul_stage u_mul_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_item   (s1_item),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_item  (s2_item)
    );

    // Stage three: channel sums, mode select and the output register.
    apc_mix_stage u_mix_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_item   (s2_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    // The result struct packs to 50 bits; the top bits of the bus are zero.
    assign m_tdata = {6'b000000, out_item};

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ARGB pixel compositor. A table of hand-picked
// pixels (register extremes, depth test edges, opaque and transparent blend
// sources, the unused mode) runs first, then about five hundred random pixels
// under random register settings with idle cycles on both streams. Each
// accepted pixel is predicted in the bench and every result item is checked
// field by field in order.
// ----------------------------------------------------------------------------
module testbench;

    // The fourth mode code has no name in the package; the block ignores it.
    localparam logic [apc_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Three register stages from acceptance to m_tvalid.
    localparam int PIPE_LATENCY = 3;

    // Random part: settings per idling phase and pixels per setting.
    localparam int SETTINGS_PER_PHASE = 6;
    localparam int PIXELS_PER_SETTING = 28;

    // One row of the directed table. When known is set, the result is typed
    // into the row; otherwise the predictor supplies it.
    typedef struct packed {
        apc_pkg::cfg_t      cfg;
        apc_pkg::in_item_t  pix;
        logic               known;
        apc_pkg::out_item_t result;
    } pixel_vec_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [apc_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [apc_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                           s_tvalid;
    logic                           s_tready;
    // s_tdata from bit 0 up: src_pixel, dst_pixel, dst_depth.
    logic [79:0]                    s_tdata;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    // m_tdata from bit 0 up: out_pixel, out_depth, pixel_write, depth_write, zero fill.
    logic [55:0]                    m_tdata;

    // Bench copy of the register file, updated only while the block is idle.
    apc_pkg::cfg_t        active_cfg;
    // Results still owed by the block, oldest first.
    apc_pkg::out_item_t   pending_pixels[$];
    pixel_vec_t           directed_pixels[$];

    // Idle percentages for each stream and a long receiver hold-off counter.
    int tx_idle_pct;
    int rx_idle_pct;
    int rx_stall_left;

    int mismatch_count;
    int results_checked;
    int directed_sent;
    int random_sent;
    int settings_used;

    argb_pixel_compositor i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Blend mode: the source alpha is first scaled by the global alpha unless
    // the global alpha is fully opaque. A source that ends up opaque is stored
    // as it is; otherwise each color channel is mixed and alpha forced opaque.
    function automatic logic [apc_pkg::PIX_W-1:0] blend_argb(
        logic [apc_pkg::PIX_W-1:0]  src,
        logic [apc_pkg::PIX_W-1:0]  dst,
        logic [apc_pkg::CHAN_W-1:0] ga);
        logic [apc_pkg::CHAN_W-1:0] a;
        logic [apc_pkg::PROD_W-1:0] scaled;
        logic [apc_pkg::PROD_W:0]   mix;
        logic [apc_pkg::PIX_W-1:0]  res;
        int                         ch;
        a = src[31:24];
        if (ga != apc_pkg::ALPHA_OPAQUE)
        begin
            scaled     = a * ga;
            a          = scaled[15:8];
            src[31:24] = a;
        end
        if (a == apc_pkg::ALPHA_OPAQUE)
            return src;
        res = {apc_pkg::ALPHA_OPAQUE, 24'h000000};
        for (ch = 0; ch < apc_pkg::NUM_CHAN; ch++)
        begin
            mix = src[ch*apc_pkg::CHAN_W +: apc_pkg::CHAN_W] * a
                + dst[ch*apc_pkg::CHAN_W +: apc_pkg::CHAN_W] * (8'd255 - a);
            res[ch*apc_pkg::CHAN_W +: apc_pkg::CHAN_W] = mix[15:8];
        end
        return res;
    endfunction

    // Works out what the block stores for one pixel under the given registers.
    // Fields that are not written carry the destination values through.
    function automatic apc_pkg::out_item_t composite_pixel(apc_pkg::cfg_t c,
                                                           apc_pkg::in_item_t p);
        apc_pkg::out_item_t r;
        r.out_pixel   = p.dst_pixel;
        r.out_depth   = p.dst_depth;
        r.pixel_write = 1'b0;
        r.depth_write = 1'b0;
        case (c.compose_mode)
            apc_pkg::MODE_COPY:
            begin
                r.out_pixel   = p.src_pixel;
                r.pixel_write = 1'b1;
            end
            apc_pkg::MODE_DEPTH_COPY:
            begin
                // Unsigned compare: the layer wins when the stored depth is
                // not above it.
                if (p.dst_depth <= c.layer_depth)
                begin
                    r.out_pixel   = p.src_pixel;
                    r.out_depth   = c.layer_depth;
                    r.pixel_write = 1'b1;
                    r.depth_write = 1'b1;
                end
            end
            apc_pkg::MODE_BLEND:
            begin
                r.out_pixel   = blend_argb(p.src_pixel, p.dst_pixel, c.global_alpha);
                r.pixel_write = 1'b1;
            end
            default:
            begin
                // Unused mode: nothing is written.
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic plan_pixel(logic [apc_pkg::MODE_W-1:0] mode,
                              logic [apc_pkg::DEPTH_W-1:0] ldep,
                              logic [apc_pkg::CHAN_W-1:0] ga,
                              logic [apc_pkg::PIX_W-1:0] src,
                              logic [apc_pkg::PIX_W-1:0] dst,
                              logic [apc_pkg::DEPTH_W-1:0] dep,
                              logic known, logic [apc_pkg::PIX_W-1:0] opix,
                              logic [apc_pkg::DEPTH_W-1:0] odep, logic pw, logic dw);
        pixel_vec_t v;
        v.cfg.compose_mode   = mode;
        v.cfg.layer_depth    = ldep;
        v.cfg.global_alpha   = ga;
        v.pix.src_pixel      = src;
        v.pix.dst_pixel      = dst;
        v.pix.dst_depth      = dep;
        v.known              = known;
        v.result.out_pixel   = opix;
        v.result.out_depth   = odep;
        v.result.pixel_write = pw;
        v.result.depth_write = dw;
        directed_pixels.push_back(v);
    endtask

    task automatic write_reg(logic [apc_pkg::CFG_ADDR_W-1:0] idx,
                             logic [apc_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    // Writes all three registers; only called while nothing is in flight.
    task automatic program_cfg(apc_pkg::cfg_t c);
        write_reg(apc_pkg::REG_COMPOSE_MODE, apc_pkg::CFG_DATA_W'(c.compose_mode));
        write_reg(apc_pkg::REG_LAYER_DEPTH,  c.layer_depth);
        write_reg(apc_pkg::REG_GLOBAL_ALPHA, apc_pkg::CFG_DATA_W'(c.global_alpha));
        cfg_we <= 1'b0;
        @(posedge clk);
        active_cfg = c;
        settings_used++;
    endtask

    // Stops offering pixels until every owed result has come back, then lets
    // the pipeline settle before returning.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    // Offers one pixel after a random gap and records its expected result
    // once the block has taken it. Valid stays high on return so that
    // back-to-back pixels follow without a gap.
    task automatic send_pixel(apc_pkg::in_item_t p, apc_pkg::out_item_t want);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        pending_pixels.push_back(want);
    endtask

    // Random pixel shaped to hit the interesting spots: source alpha at its
    // extremes for blending, stored depth at the layer depth edge or its extremes.
    function automatic apc_pkg::in_item_t random_pixel(apc_pkg::cfg_t c);
        apc_pkg::in_item_t p;
        p.src_pixel = $urandom;
        p.dst_pixel = $urandom;
        p.dst_depth = apc_pkg::DEPTH_W'($urandom);
        case ($urandom_range(0, 3))
            0: p.src_pixel[31:24] = 8'h00;
            1: p.src_pixel[31:24] = apc_pkg::ALPHA_OPAQUE;
            default: ;
        endcase
        case ($urandom_range(0, 6))
            0: p.dst_depth = c.layer_depth;
            1: p.dst_depth = c.layer_depth + 16'd1;
            2: p.dst_depth = c.layer_depth - 16'd1;
            3: p.dst_depth = 16'h0000;
            4: p.dst_depth = 16'hFFFF;
            default: ;
        endcase
        return p;
    endfunction

    // Register setting for one stretch of random pixels. Blend and depth test
    // get most of the weight; the layer depth and global alpha rotate through
    // their extremes and random values.
    function automatic apc_pkg::cfg_t random_cfg(int k);
        apc_pkg::cfg_t c;
        int            pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            c.compose_mode = apc_pkg::MODE_COPY;
        else if (pick < 5)
            c.compose_mode = apc_pkg::MODE_DEPTH_COPY;
        else if (pick < 9)
            c.compose_mode = apc_pkg::MODE_BLEND;
        else
            c.compose_mode = MODE_UNUSED;
        case (k % 3)
            0: c.layer_depth = 16'hFFFF;
            1: c.layer_depth = 16'h0000;
            default: c.layer_depth = apc_pkg::DEPTH_W'($urandom);
        endcase
        case ((k + 1) % 3)
            0: c.global_alpha = 8'h00;
            1: c.global_alpha = apc_pkg::ALPHA_OPAQUE;
            default: c.global_alpha = apc_pkg::CHAN_W'($urandom);
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic compare_field(string name, logic [apc_pkg::PIX_W-1:0] want,
                                 logic [apc_pkg::PIX_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result(apc_pkg::out_item_t got);
        apc_pkg::out_item_t want;
        if (pending_pixels.size() == 0)
        begin
            $display("%0t: result item with nothing expected, got %h", $time, got);
            mismatch_count++;
        end
        else
        begin
            want = pending_pixels.pop_front();
            compare_field("out_pixel", want.out_pixel, got.out_pixel);
            compare_field("out_depth", apc_pkg::PIX_W'(want.out_depth),
                          apc_pkg::PIX_W'(got.out_depth));
            compare_field("pixel_write", apc_pkg::PIX_W'(want.pixel_write),
                          apc_pkg::PIX_W'(got.pixel_write));
            compare_field("depth_write", apc_pkg::PIX_W'(want.depth_write),
                          apc_pkg::PIX_W'(got.depth_write));
            results_checked++;
        end
    endtask

    // Receiver: takes result items and decides m_tready for the next cycle.
    // A long hold-off, when requested, keeps m_tready low so the pipeline
    // fills up and pushes back on the input stream.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            check_result(apc_pkg::out_item_t'(m_tdata[49:0]));
        if (rx_stall_left > 0)
        begin
            rx_stall_left = rx_stall_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        pixel_vec_t         v;
        apc_pkg::out_item_t want;
        apc_pkg::in_item_t  p;
        apc_pkg::cfg_t      c;
        int                 phase;
        int                 k;
        int                 n;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_addr        = '0;
        cfg_wdata       = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        tx_idle_pct     = 0;
        rx_idle_pct     = 0;
        rx_stall_left   = 0;
        mismatch_count  = 0;
        results_checked = 0;
        directed_sent   = 0;
        random_sent     = 0;
        settings_used   = 0;

        // The bench model starts from the documented reset values.
        active_cfg.compose_mode = apc_pkg::RESET_MODE;
        active_cfg.layer_depth  = apc_pkg::RESET_LAYER_DEPTH;
        active_cfg.global_alpha = apc_pkg::RESET_GLOBAL_ALPHA;

        // Directed table. The first rows run on the reset registers without
        // any write, so they also check the reset values.
        // Plain copy, pixel and depth extremes.
        plan_pixel(apc_pkg::MODE_COPY, 16'h0000, 8'hFF, 32'hFFFFFFFF, 32'h00000000,
                   16'h0000, 1'b1, 32'hFFFFFFFF, 16'h0000, 1'b1, 1'b0);
        plan_pixel(apc_pkg::MODE_COPY, 16'h0000, 8'hFF, 32'h00000000, 32'hFFFFFFFF,
                   16'hFFFF, 1'b1, 32'h00000000, 16'hFFFF, 1'b1, 1'b0);
        plan_pixel(apc_pkg::MODE_COPY, 16'h0000, 8'hFF, 32'h12345678, 32'h9ABCDEF0,
                   16'h1234, 1'b0, '0, '0, 1'b0, 1'b0);
        // Depth test at layer depth zero: equal passes, one above fails and
        // leaves the destination fields untouched.
        plan_pixel(apc_pkg::MODE_DEPTH_COPY, 16'h0000, 8'hFF, 32'hA5A5A5A5, 32'h5A5A5A5A,
                   16'h0000, 1'b1, 32'hA5A5A5A5, 16'h0000, 1'b1, 1'b1);
        plan_pixel(apc_pkg::MODE_DEPTH_COPY, 16'h0000, 8'hFF, 32'hA5A5A5A5, 32'h5A5A5A5A,
                   16'h0001, 1'b1, 32'h5A5A5A5A, 16'h0001, 1'b0, 1'b0);
        // Depth test at the top layer depth: everything passes.
        plan_pixel(apc_pkg::MODE_DEPTH_COPY, 16'hFFFF, 8'hFF, 32'h00000000, 32'hFFFFFFFF,
                   16'hFFFF, 1'b1, 32'h00000000, 16'hFFFF, 1'b1, 1'b1);
        plan_pixel(apc_pkg::MODE_DEPTH_COPY, 16'hFFFF, 8'hFF, 32'hFFFFFFFF, 32'h00000000,
                   16'h0000, 1'b1, 32'hFFFFFFFF, 16'hFFFF, 1'b1, 1'b1);
        // Mid-range layer depth, checking the compare is unsigned.
        plan_pixel(apc_pkg::MODE_DEPTH_COPY, 16'h8000, 8'hFF, 32'h01020304, 32'h05060708,
                   16'h8000, 1'b0, '0, '0, 1'b0, 1'b0);
        plan_pixel(apc_pkg::MODE_DEPTH_COPY, 16'h8000, 8'hFF, 32'h01020304, 32'h05060708,
                   16'h8001, 1'b0, '0, '0, 1'b0, 1'b0);
        plan_pixel(apc_pkg::MODE_DEPTH_COPY, 16'h8000, 8'hFF, 32'h01020304, 32'h05060708,
                   16'h7FFF, 1'b0, '0, '0, 1'b0, 1'b0);
        // Blend, global alpha opaque: an opaque source passes through and
        // depth is never written.
        plan_pixel(apc_pkg::MODE_BLEND, 16'h8000, 8'hFF, 32'hFF123456, 32'h00ABCDEF,
                   16'h4321, 1'b1, 32'hFF123456, 16'h4321, 1'b1, 1'b0);
        plan_pixel(apc_pkg::MODE_BLEND, 16'h8000, 8'hFF, 32'h00FFFFFF, 32'hFFFFFFFF,
                   16'h0000, 1'b0, '0, '0, 1'b0, 1'b0);
        plan_pixel(apc_pkg::MODE_BLEND, 16'h8000, 8'hFF, 32'h80FF0000, 32'h0000FF00,
                   16'hFFFF, 1'b0, '0, '0, 1'b0, 1'b0);
        plan_pixel(apc_pkg::MODE_BLEND, 16'h8000, 8'hFF, 32'hFE010203, 32'hFDFCFBFA,
                   16'h1111, 1'b0, '0, '0, 1'b0, 1'b0);
        // Blend, global alpha zero: every source becomes fully transparent.
        plan_pixel(apc_pkg::MODE_BLEND, 16'h0000, 8'h00, 32'hFFFFFFFF, 32'h00000000,
                   16'h0000, 1'b0, '0, '0, 1'b0, 1'b0);
        plan_pixel(apc_pkg::MODE_BLEND, 16'h0000, 8'h00, 32'h7F808080, 32'h7F7F7F7F,
                   16'hFFFF, 1'b0, '0, '0, 1'b0, 1'b0);
        // Blend with a half global alpha: an opaque source is no longer opaque.
        plan_pixel(apc_pkg::MODE_BLEND, 16'h0000, 8'h80, 32'hFF00FF00, 32'hFF0000FF,
                   16'h2222, 1'b0, '0, '0, 1'b0, 1'b0);
        plan_pixel(apc_pkg::MODE_BLEND, 16'h0000, 8'h80, 32'h01FFFFFF, 32'h00000000,
                   16'h3333, 1'b0, '0, '0, 1'b0, 1'b0);
        plan_pixel(apc_pkg::MODE_BLEND, 16'h0000, 8'h01, 32'hFFFFFFFF, 32'hFFFFFFFF,
                   16'h4444, 1'b0, '0, '0, 1'b0, 1'b0);
        // Unused mode: nothing is written, destination fields pass through.
        plan_pixel(MODE_UNUSED, 16'hFFFF, 8'h00, 32'hFFFFFFFF, 32'h13579BDF, 16'h2468,
                   1'b1, 32'h13579BDF, 16'h2468, 1'b0, 1'b0);
        plan_pixel(MODE_UNUSED, 16'hFFFF, 8'h00, 32'h00000000, 32'h00000000, 16'hFFFF,
                   1'b1, 32'h00000000, 16'hFFFF, 1'b0, 1'b0);
        // Back to plain copy after the unused mode.
        plan_pixel(apc_pkg::MODE_COPY, 16'h0000, 8'hFF, 32'h0F1E2D3C, 32'hC3D2E1F0,
                   16'h5555, 1'b0, '0, '0, 1'b0, 1'b0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling on either side. Registers change only
        // once every owed result has come back.
        foreach (directed_pixels[i])
        begin
            v = directed_pixels[i];
            if (v.cfg != active_cfg)
            begin
                wait_drained();
                program_cfg(v.cfg);
            end
            want = v.known ? v.result : composite_pixel(active_cfg, v.pix);
            send_pixel(v.pix, want);
            directed_sent++;
        end

        // Random part in three idling phases: receiver mostly idle, then the
        // sender mostly idle, then full rate on both sides.
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct = 36;
                    rx_idle_pct = 58;
                end
                1:
                begin
                    tx_idle_pct = 58;
                    rx_idle_pct = 36;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (k = 0; k < SETTINGS_PER_PHASE; k++)
            begin
                // Every register change is preceded by a full drain, so the
                // sender also sits idle until nothing is owed.
                wait_drained();
                c = random_cfg(k);
                program_cfg(c);
                // At full rate, hold the receiver off long enough that all
                // stages fill and the block must stall its input.
                if (phase == 2 && k == 0)
                    rx_stall_left = 200;
                for (n = 0; n < PIXELS_PER_SETTING; n++)
                begin
                    p = random_pixel(active_cfg);
                    send_pixel(p, composite_pixel(active_cfg, p));
                    random_sent++;
                end
            end
        end

        wait_drained();

        $display("Covered %0d directed and %0d random pixels over %0d register settings.",
                 directed_sent, random_sent, settings_used);
        $display("Checked %0d result items, %0d mismatches.", results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("[argb_pixel_compositor] OK");
        else
            $display("[argb_pixel_compositor] ERROR");
        $finish;
    end

    // Watchdog: the slowest correct run needs far fewer cycles than this.
    initial
    begin
        #2000000;
        $display("Timed out with %0d result items still owed.", pending_pixels.size());
        $display("[argb_pixel_compositor] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
sv/apc_pkg.sv
sv/apc_cfg_regs.sv
sv/apc_alpha_stage.sv
sv/apc_mul_stage.sv
sv/apc_mix_stage.sv
sv/argb_pixel_compositor.sv
tb/testbench.sv
